@@ rtl/core/plj_pkg.sv @@
// Package for the planar 3R Jacobian pipeline: constants, types and math helpers.
`default_nettype none
package plj_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_ITER      = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    localparam int ANG_W  = 16;
    localparam int LEN_W  = 15;
    localparam int Q30_W  = 33;
    localparam int TERM_W = 18;
    localparam int SUM_W  = 20;
    localparam int OUT_W  = 17;
    localparam int NUM_LANES = 3;

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [Q30_W-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [SUM_W-1:0] OUT_MAX = 20'sd65535;
    localparam logic signed [SUM_W-1:0] OUT_MIN = -20'sd65536;

    localparam logic [1:0] REG_LINK_ONE   = 2'd0;
    localparam logic [1:0] REG_LINK_TWO   = 2'd1;
    localparam logic [1:0] REG_LINK_THREE = 2'd2;

    localparam logic [LEN_W-1:0] LINK_ONE_RST   = 15'd16384;
    localparam logic [LEN_W-1:0] LINK_TWO_RST   = 15'd10895;
    localparam logic [LEN_W-1:0] LINK_THREE_RST = 15'd7137;

    typedef struct packed {
        logic signed [Q30_W-1:0] x;
        logic signed [Q30_W-1:0] y;
        logic signed [Q30_W-1:0] z;
        logic                    neg;
    } t_lane;

    typedef struct packed {
        logic [LEN_W-1:0] len_one;
        logic [LEN_W-1:0] len_two;
        logic [LEN_W-1:0] len_three;
    } t_links;

    function automatic logic signed [Q30_W-1:0] atan_q30(input int idx);
        logic signed [Q30_W-1:0] v;
        case (idx)
            0:  v = 33'sh03243F6A8;
            1:  v = 33'sh01DAC6705;
            2:  v = 33'sh00FADBAFC;
            3:  v = 33'sh007F56EA6;
            4:  v = 33'sh003FEAB76;
            5:  v = 33'sh001FFD55B;
            6:  v = 33'sh000FFFAAA;
            7:  v = 33'sh0007FFF55;
            8:  v = 33'sh0003FFFEA;
            9:  v = 33'sh0001FFFFD;
            10: v = 33'sh0000FFFFF;
            11: v = 33'sh00007FFFF;
            12: v = 33'sh00003FFFF;
            13: v = 33'sh00001FFFF;
            14: v = 33'sh00000FFFF;
            15: v = 33'sh000007FFF;
            16: v = 33'sh000003FFF;
            17: v = 33'sh000001FFF;
            18: v = 33'sh000000FFF;
            19: v = 33'sh0000007FF;
            20: v = 33'sh0000003FF;
            21: v = 33'sh0000001FF;
            22: v = 33'sh0000000FF;
            23: v = 33'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // one add/sub of 2*pi is enough for every reachable sum
    function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [17:0] v);
        logic signed [17:0] t;
        t = v;
        if (v > PI_Q13) begin
            t = v - TWO_PI_Q13;
        end else if (v < -PI_Q13) begin
            t = v + TWO_PI_Q13;
        end
        return t[ANG_W-1:0];
    endfunction

    function automatic t_lane cordic_step(input t_lane l, input int idx);
        t_lane r;
        r = l;
        if (!l.z[Q30_W-1]) begin
            r.x = l.x - (l.y >>> idx);
            r.y = l.y + (l.x >>> idx);
            r.z = l.z - atan_q30(idx);
        end else begin
            r.x = l.x + (l.y >>> idx);
            r.y = l.y - (l.x >>> idx);
            r.z = l.z + atan_q30(idx);
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v;
        if (v > OUT_MAX) begin
            t = OUT_MAX;
        end else if (v < OUT_MIN) begin
            t = OUT_MIN;
        end
        return t[OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/plj_angle_prep.sv @@
// Angle sums with wrap, then quadrant fold into CORDIC start lanes (four stages).
`default_nettype none
module plj_angle_prep (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  wire                               i_valid,
    input  wire  [3*plj_pkg::ANG_W-1:0]       i_angles,
    output logic                              o_valid,
    output plj_pkg::t_lane [plj_pkg::NUM_LANES-1:0] o_lanes
);

    logic [2:0] r_valid;
    logic signed [plj_pkg::ANG_W-1:0] r_p1_a, r_a2_a, r_a3_a;
    logic signed [plj_pkg::ANG_W-1:0] r_p1_b, r_p2_b, r_a3_b;
    logic signed [plj_pkg::ANG_W-1:0] r_p1_c, r_p2_c, r_p3_c;
    plj_pkg::t_lane [plj_pkg::NUM_LANES-1:0] n_lanes;
    logic signed [plj_pkg::ANG_W-1:0] w_p [plj_pkg::NUM_LANES];

    always_comb begin
        w_p[0] = r_p1_c;
        w_p[1] = r_p2_c;
        w_p[2] = r_p3_c;
        for (int k = 0; k < plj_pkg::NUM_LANES; k++) begin
            logic signed [17:0] a;
            a = 18'(w_p[k]);
            n_lanes[k].neg = 1'b0;
            if (a > plj_pkg::HALF_PI_Q13) begin
                a = a - plj_pkg::PI_Q13;
                n_lanes[k].neg = 1'b1;
            end else if (a < -plj_pkg::HALF_PI_Q13) begin
                a = a + plj_pkg::PI_Q13;
                n_lanes[k].neg = 1'b1;
            end
            n_lanes[k].x = plj_pkg::GAIN_Q30;
            n_lanes[k].y = '0;
            n_lanes[k].z = plj_pkg::Q30_W'(a) <<< 17;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
            o_valid <= r_valid[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_a  <= plj_pkg::wrap_angle(18'($signed(i_angles[15:0])));
            r_a2_a  <= $signed(i_angles[31:16]);
            r_a3_a  <= $signed(i_angles[47:32]);
            r_p1_b  <= r_p1_a;
            r_p2_b  <= plj_pkg::wrap_angle(18'(r_p1_a) + 18'(r_a2_a));
            r_a3_b  <= r_a3_a;
            r_p1_c  <= r_p1_b;
            r_p2_c  <= r_p2_b;
            r_p3_c  <= plj_pkg::wrap_angle(18'(r_p2_b) + 18'(r_a3_b));
            o_lanes <= n_lanes;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/plj_cordic.sv @@
// Three-lane rotation-mode CORDIC, one iteration per pipeline stage.
`default_nettype none
module plj_cordic (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_en,
    input  wire                                      i_valid,
    input  plj_pkg::t_lane [plj_pkg::NUM_LANES-1:0] i_lanes,
    output logic                                     o_valid,
    output plj_pkg::t_lane [plj_pkg::NUM_LANES-1:0] o_lanes
);

    for (genvar s = 0; s < plj_pkg::NUM_ITER; s++) begin : g_iter
        logic                                    w_valid_in;
        plj_pkg::t_lane [plj_pkg::NUM_LANES-1:0] w_lanes_in;
        logic                                    r_valid;
        plj_pkg::t_lane [plj_pkg::NUM_LANES-1:0] r_lanes;

        if (s == 0) begin : g_first
            assign w_valid_in = i_valid;
            assign w_lanes_in = i_lanes;
        end else begin : g_next
            assign w_valid_in = g_iter[s-1].r_valid;
            assign w_lanes_in = g_iter[s-1].r_lanes;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < plj_pkg::NUM_LANES; k++) begin
                    r_lanes[k] <= plj_pkg::cordic_step(w_lanes_in[k], s);
                end
            end
        end
    end

    assign o_valid = g_iter[plj_pkg::NUM_ITER-1].r_valid;
    assign o_lanes = g_iter[plj_pkg::NUM_ITER-1].r_lanes;

endmodule
`default_nettype wire

@@ rtl/core/plj_scale.sv @@
// Link scaling multiply with rounding, column sums and saturation (two stages).
`default_nettype none
module plj_scale (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_en,
    input  wire                                      i_valid,
    input  plj_pkg::t_lane [plj_pkg::NUM_LANES-1:0] i_lanes,
    input  plj_pkg::t_links                          i_links,
    output logic                                     o_valid,
    output logic [6*plj_pkg::OUT_W-1:0]              o_cols
);

    localparam int PROD_W = plj_pkg::Q30_W + plj_pkg::LEN_W + 1;

    logic r_valid;
    logic signed [plj_pkg::TERM_W-1:0] r_ux [plj_pkg::NUM_LANES];
    logic signed [plj_pkg::TERM_W-1:0] r_uy [plj_pkg::NUM_LANES];
    logic signed [plj_pkg::TERM_W-1:0] n_ux [plj_pkg::NUM_LANES];
    logic signed [plj_pkg::TERM_W-1:0] n_uy [plj_pkg::NUM_LANES];
    logic [plj_pkg::LEN_W-1:0] w_len [plj_pkg::NUM_LANES];
    logic signed [plj_pkg::SUM_W-1:0] w_sx [plj_pkg::NUM_LANES];
    logic signed [plj_pkg::SUM_W-1:0] w_sy [plj_pkg::NUM_LANES];
    logic [6*plj_pkg::OUT_W-1:0] n_cols;

    assign w_len[0] = i_links.len_one;
    assign w_len[1] = i_links.len_two;
    assign w_len[2] = i_links.len_three;

    always_comb begin
        for (int k = 0; k < plj_pkg::NUM_LANES; k++) begin
            logic signed [plj_pkg::Q30_W-1:0] c, s;
            logic signed [PROD_W-1:0] pc, ps, len;
            c   = i_lanes[k].neg ? -i_lanes[k].x : i_lanes[k].x;
            s   = i_lanes[k].neg ? -i_lanes[k].y : i_lanes[k].y;
            len = $signed({{(PROD_W-plj_pkg::LEN_W){1'b0}}, w_len[k]});
            pc  = len * PROD_W'(c) + (PROD_W'(1) <<< 29);
            ps  = len * PROD_W'(s) + (PROD_W'(1) <<< 29);
            pc  = pc >>> 30;
            ps  = ps >>> 30;
            n_ux[k] = pc[plj_pkg::TERM_W-1:0];
            n_uy[k] = ps[plj_pkg::TERM_W-1:0];
        end
    end

    always_comb begin
        w_sx[2] = plj_pkg::SUM_W'(r_ux[2]);
        w_sy[2] = plj_pkg::SUM_W'(r_uy[2]);
        w_sx[1] = w_sx[2] + plj_pkg::SUM_W'(r_ux[1]);
        w_sy[1] = w_sy[2] + plj_pkg::SUM_W'(r_uy[1]);
        w_sx[0] = w_sx[1] + plj_pkg::SUM_W'(r_ux[0]);
        w_sy[0] = w_sy[1] + plj_pkg::SUM_W'(r_uy[0]);
        for (int k = 0; k < plj_pkg::NUM_LANES; k++) begin
            n_cols[2*k*plj_pkg::OUT_W +: plj_pkg::OUT_W]     = plj_pkg::saturate(-w_sy[k]);
            n_cols[(2*k+1)*plj_pkg::OUT_W +: plj_pkg::OUT_W] = plj_pkg::saturate(w_sx[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            o_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ux   <= n_ux;
            r_uy   <= n_uy;
            o_cols <= n_cols;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/planar_3r_jacobian.sv @@
// Top level of the planar 3R arm Jacobian pipeline.
// Takes one angle triple per cycle while o_s_tready is high and returns the six
// linear Jacobian entries (Q13, saturated to 17 bits) through four angle
// stages, one CORDIC iteration per stage, and two scaling/sum stages. The
// whole pipeline advances whenever the output register is empty or being
// taken, so throughput is one transaction per cycle. Link lengths are
// written through the config port and must stay stable while items are in
// flight.
`default_nettype none
module planar_3r_jacobian (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // angle_one, angle_two, angle_three
    input  wire  [47:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // col_one_x, col_one_y, col_two_x, col_two_y, col_three_x, col_three_y, zero pad
    output logic [103:0] o_m_tdata,
    input  wire          i_cfg_wr_en,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [14:0]  i_cfg_data
);

    logic en;
    plj_pkg::t_links r_links;
    logic prep_valid, cordic_valid;
    plj_pkg::t_lane [plj_pkg::NUM_LANES-1:0] prep_lanes, cordic_lanes;
    logic [6*plj_pkg::OUT_W-1:0] cols;

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tdata  = {2'b00, cols};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_links.len_one   <= plj_pkg::LINK_ONE_RST;
            r_links.len_two   <= plj_pkg::LINK_TWO_RST;
            r_links.len_three <= plj_pkg::LINK_THREE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                plj_pkg::REG_LINK_ONE:   r_links.len_one   <= i_cfg_data;
                plj_pkg::REG_LINK_TWO:   r_links.len_two   <= i_cfg_data;
                plj_pkg::REG_LINK_THREE: r_links.len_three <= i_cfg_data;
                default: ;
            endcase
        end
    end

    plj_angle_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_s_tvalid),
        .i_angles (i_s_tdata),
        .o_valid  (prep_valid),
        .o_lanes  (prep_lanes)
    );

    plj_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_lanes (prep_lanes),
        .o_valid (cordic_valid),
        .o_lanes (cordic_lanes)
    );

    plj_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cordic_valid),
        .i_lanes (cordic_lanes),
        .i_links (r_links),
        .o_valid (o_m_tvalid),
        .o_cols  (cols)
    );

endmodule
`default_nettype wire

@@ rtl/core/plj_checker.sv @@
// Port-level checker for planar_3r_jacobian, bound to the top level.
`default_nettype none
module plj_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_s_tready,
    input wire [103:0] o_m_tdata,
    input wire         o_m_tvalid,
    input wire         i_m_tready
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output transaction changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[103:102] == 2'b00)
        else $error("pad bits set");

endmodule

bind planar_3r_jacobian plj_checker u_plj_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);
`default_nettype wire

@@ tb/planar_3r_jacobian_test.sv @@
// Self-checking testbench for the planar 3R Jacobian pipeline.
`timescale 1ns / 100ps
`default_nettype none
module planar_3r_jacobian_test;

    typedef struct packed {
        logic signed [15:0] a3;
        logic signed [15:0] a2;
        logic signed [15:0] a1;
    } t_angles;

    typedef struct {
        logic [16:0] f [6];
    } t_jac;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [47:0]  i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [103:0] o_m_tdata;
    logic         i_cfg_wr_en;
    logic [1:0]   i_cfg_index;
    logic [14:0]  i_cfg_data;

    planar_3r_jacobian dut (.*);

    t_angles     pending_q[$];
    t_jac        jacobian_q[$];
    logic [14:0] len_one, len_two, len_three;
    int          mismatches;
    int          gap_left;
    int          stall_left;
    bit          hold_sender;

    localparam longint ATAN_TBL [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    function automatic int fold_pi(int a);
        int r;
        r = a;
        while (r > 25736) r -= 51472;
        while (r < -25736) r += 51472;
        return r;
    endfunction

    function automatic void sincos_q30(int ang, output longint c, output longint s);
        longint x, y, z, nx;
        bit     neg;
        int     a;
        a = fold_pi(ang);
        neg = 0;
        if (a > 12868) begin
            a -= 25736;
            neg = 1;
        end else if (a < -12868) begin
            a += 25736;
            neg = 1;
        end
        x = 652032874;
        y = 0;
        z = longint'(a) * 131072;
        for (int i = 0; i < plj_pkg::NUM_ITER; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_TBL[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_TBL[i];
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint link_term(logic [14:0] len, longint t);
        return (longint'(len) * t + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [16:0] clamp17(longint v);
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return v[16:0];
    endfunction

    function automatic t_jac jacobian_of(t_angles a);
        t_jac   j;
        int     p1, p2, p3;
        longint c, s, ux1, uy1, ux2, uy2, ux3, uy3;
        p1 = fold_pi(a.a1);
        p2 = fold_pi(p1 + a.a2);
        p3 = fold_pi(p2 + a.a3);
        sincos_q30(p1, c, s);
        ux1 = link_term(len_one, c);
        uy1 = link_term(len_one, s);
        sincos_q30(p2, c, s);
        ux2 = link_term(len_two, c);
        uy2 = link_term(len_two, s);
        sincos_q30(p3, c, s);
        ux3 = link_term(len_three, c);
        uy3 = link_term(len_three, s);
        j.f[0] = clamp17(-(uy1 + uy2 + uy3));
        j.f[1] = clamp17(ux1 + ux2 + ux3);
        j.f[2] = clamp17(-(uy2 + uy3));
        j.f[3] = clamp17(ux2 + ux3);
        j.f[4] = clamp17(-uy3);
        j.f[5] = clamp17(ux3);
        return j;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 0;
            gap_left <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                jacobian_q.push_back(jacobian_of(t_angles'(i_s_tdata)));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    i_s_tvalid <= 0;
                    gap_left <= gap_left - 1;
                end else if (pending_q.size() > 0 && !hold_sender) begin
                    i_s_tvalid <= 1;
                    i_s_tdata <= pending_q.pop_front();
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                end else begin
                    i_s_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_jac exp_j;
        if (!i_rst_n) begin
            i_m_tready <= 0;
            stall_left <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (jacobian_q.size() == 0) begin
                    report_mismatch("unexpected result transaction");
                end else begin
                    exp_j = jacobian_q.pop_front();
                    for (int k = 0; k < 6; k++) begin
                        if (o_m_tdata[17*k +: 17] !== exp_j.f[k])
                            report_mismatch($sformatf("field %0d got %h exp %h", k,
                                o_m_tdata[17*k +: 17], exp_j.f[k]));
                    end
                end
            end
            if (stall_left > 0) begin
                i_m_tready <= 0;
                stall_left <= stall_left - 1;
            end else begin
                i_m_tready <= 1;
                if (o_m_tvalid && i_m_tready)
                    stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
        end
    end

    task automatic wait_drained();
        while (pending_q.size() > 0 || i_s_tvalid || jacobian_q.size() > 0)
            @(posedge i_clk);
        repeat (plj_pkg::NUM_ITER + 10) @(posedge i_clk);
    endtask

    task automatic write_link(logic [1:0] idx, logic [14:0] v);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        case (idx)
            plj_pkg::REG_LINK_ONE:   len_one = v;
            plj_pkg::REG_LINK_TWO:   len_two = v;
            plj_pkg::REG_LINK_THREE: len_three = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'(25736 - $urandom_range(0, 3));
            2: return 16'(-25736 + $urandom_range(0, 3));
            default: return 16'($signed($urandom_range(0, 51472)) - 25736);
        endcase
    endfunction

    task automatic push_angles(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3);
        pending_q.push_back({a3, a2, a1});
    endtask

    initial begin
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_m_tready = 0;
        i_cfg_wr_en = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        hold_sender = 0;
        mismatches = 0;
        len_one = plj_pkg::LINK_ONE_RST;
        len_two = plj_pkg::LINK_TWO_RST;
        len_three = plj_pkg::LINK_THREE_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: zero, extremes, quadrant edges, wrap, out of range bits
        push_angles(0, 0, 0);
        push_angles(16'sd25736, 16'sd25736, 16'sd25736);
        push_angles(-16'sd25736, -16'sd25736, -16'sd25736);
        push_angles(16'sd12868, 16'sd12869, -16'sd12868);
        push_angles(-16'sd12869, 16'sd12867, 16'sd1);
        push_angles(16'h7FFF, 16'h8000, 16'hFFFF);
        push_angles(16'h8000, 16'h7FFF, 16'h5555);
        push_angles(16'hAAAA, 16'h5555, 16'hAAAA);
        push_angles(16'sd6434, 16'sd19302, -16'sd6434);
        push_angles(-16'sd1, 16'sd1, 16'sd25735);
        wait_drained();

        // extreme lengths: saturation and zero
        write_link(plj_pkg::REG_LINK_ONE, 15'h7FFF);
        write_link(plj_pkg::REG_LINK_TWO, 15'h7FFF);
        write_link(plj_pkg::REG_LINK_THREE, 15'h7FFF);
        push_angles(0, 0, 0);
        push_angles(16'sd25736, 0, 0);
        push_angles(16'sd12868, 0, 0);
        push_angles(-16'sd12868, 0, 0);
        push_angles(16'sd6434, 16'sd0, 16'sd0);
        for (int i = 0; i < 60; i++) push_angles(rand_angle(), rand_angle(), rand_angle());
        wait_drained();
        write_link(plj_pkg::REG_LINK_ONE, 0);
        write_link(plj_pkg::REG_LINK_TWO, 0);
        write_link(plj_pkg::REG_LINK_THREE, 0);
        write_link(2'd3, 15'h1234);
        for (int i = 0; i < 40; i++) push_angles(rand_angle(), rand_angle(), rand_angle());
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            write_link(plj_pkg::REG_LINK_ONE, 15'($urandom));
            write_link(plj_pkg::REG_LINK_TWO, 15'($urandom));
            write_link(plj_pkg::REG_LINK_THREE, 15'($urandom));
            for (int i = 0; i < 90; i++) push_angles(rand_angle(), rand_angle(), rand_angle());
            if (ph == 2) begin
                // sender holds until the pipeline has fully drained
                while (pending_q.size() > 45) @(posedge i_clk);
                hold_sender = 1;
                @(posedge i_clk);
                while (i_s_tvalid || jacobian_q.size() > 0) @(posedge i_clk);
                hold_sender = 0;
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
